FILE: sv/assert_macros.svh
// Assertion macros shared by the response field parser RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define CRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked only outside reset.
`define CRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: sv/crp_pkg.sv
// Types and constants for the registration reply field parser.
// No dependencies; used by the interfaces and every module.
package crp_pkg;

    // Line length limit and the derived offset counter width.
    localparam int MAX_LINE = 256;
    localparam int OFF_W    = $clog2(MAX_LINE + 1);
    localparam int POS_W    = 8;
    localparam int BYTE_W   = 8;
    localparam int NUM_W    = 8;
    localparam int STATUS_W = 9;

    // Characters that steer the scanner.
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    // Status value reported on a failed parse (minus one).
    localparam logic [STATUS_W-1:0] STATUS_ERR = '1;
    localparam logic [NUM_W-1:0]    NUM_SAT    = '1;
    localparam int                  RADIX      = 10;

    // Scanner phases over the reply line.
    typedef enum logic [3:0] {
        PH_SEEK_COLON,
        PH_SKIP_F1,
        PH_IN_F1,
        PH_START_F2,
        PH_IN_F2,
        PH_SKIP_F3,
        PH_IN_F3,
        PH_SKIP_F4,
        PH_DONE
    } t_scan_phase;

    // Decimal number parser stages.
    typedef enum logic [2:0] {
        NUM_SKIP,
        NUM_SIGN,
        NUM_DIGITS,
        NUM_END_OK,
        NUM_END_BAD
    } t_num_stage;

    // Scanner state after the current byte, as seen by the result logic.
    typedef struct packed {
        logic             in_range;
        logic             active;
        logic             feed_f1;
        logic             feed_f2;
        logic [2:0]       seen;
        logic [POS_W-1:0] start_f2;
        logic [POS_W-1:0] start_f3;
        logic [POS_W-1:0] start_f4;
    } t_scan_info;

    // Number parser state after the current byte.
    typedef struct packed {
        logic             has_digits;
        logic             negative;
        logic [NUM_W-1:0] value;
    } t_num_info;

endpackage

FILE: sv/crp_if.sv
// Valid/ready channel interfaces for reply bytes and parse results.
// Depends on crp_pkg for field widths.
interface crp_byte_if;
    import crp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] line_byte;
    logic              end_of_line;

    modport source (output valid, output line_byte, output end_of_line, input ready);
    modport sink   (input valid, input line_byte, input end_of_line, output ready);
endinterface

interface crp_result_if;
    import crp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       parse_ok;
    logic                       registered;
    logic signed [STATUS_W-1:0] reg_status;
    logic                       area_valid;
    logic [POS_W-1:0]           area_pos;
    logic                       cell_valid;
    logic [POS_W-1:0]           cell_pos;

    modport source (
        output valid, output parse_ok, output registered, output reg_status,
        output area_valid, output area_pos, output cell_valid, output cell_pos,
        input ready
    );
    modport sink (
        input valid, input parse_ok, input registered, input reg_status,
        input area_valid, input area_pos, input cell_valid, input cell_pos,
        output ready
    );
endinterface

FILE: sv/crp_number.sv
// Streaming decimal number parser: white space, optional sign, digits.
// Depends on crp_pkg for stage encoding and the result struct.
module crp_number (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_feed,
    input  logic                       i_clear,
    input  logic [crp_pkg::BYTE_W-1:0] i_byte,
    output crp_pkg::t_num_info         o_info
);
    import crp_pkg::*;

    t_num_stage        r_stage, n_stage;
    logic [NUM_W-1:0]  r_value, n_value;
    logic              r_negative, n_negative;

    logic              is_white;
    logic              is_digit;
    logic [3:0]        digit;
    logic [NUM_W+3:0]  acc;

    // Character classes and the times-ten accumulate.
    always_comb begin
        is_white = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));
        is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        digit    = i_byte[3:0];
        acc      = (NUM_W+4)'({r_value, 3'b000}) + (NUM_W+4)'({r_value, 1'b0})
                 + (NUM_W+4)'(digit);
    end

    // Stage transitions for one byte.
    always_comb begin
        n_stage    = r_stage;
        n_value    = r_value;
        n_negative = r_negative;
        if (i_feed) begin
            unique case (r_stage)
                NUM_SKIP: begin
                    if (is_white) begin
                        n_stage = NUM_SKIP;
                    end else if ((i_byte == CH_PLUS) || (i_byte == CH_MINUS)) begin
                        n_negative = (i_byte == CH_MINUS);
                        n_stage    = NUM_SIGN;
                    end else if (is_digit) begin
                        n_value = NUM_W'(digit);
                        n_stage = NUM_DIGITS;
                    end else begin
                        n_stage = NUM_END_BAD;
                    end
                end
                NUM_SIGN: begin
                    if (is_digit) begin
                        n_value = NUM_W'(digit);
                        n_stage = NUM_DIGITS;
                    end else begin
                        n_stage = NUM_END_BAD;
                    end
                end
                NUM_DIGITS: begin
                    if (is_digit) begin
                        n_value = (acc > (NUM_W+4)'(NUM_SAT)) ? NUM_SAT : acc[NUM_W-1:0];
                    end else begin
                        n_stage = NUM_END_OK;
                    end
                end
                default: begin
                    n_stage = r_stage;
                end
            endcase
        end
    end

    // The result logic sees the state after this byte.
    assign o_info.has_digits = (n_stage == NUM_DIGITS) || (n_stage == NUM_END_OK);
    assign o_info.negative   = n_negative;
    assign o_info.value      = n_value;

    // State registers, cleared at the end of each line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_stage    <= NUM_SKIP;
            r_value    <= '0;
            r_negative <= 1'b0;
        end else begin
            r_stage    <= n_stage;
            r_value    <= n_value;
            r_negative <= n_negative;
        end
    end

endmodule

FILE: sv/crp_scanner.sv
// Field scanner: finds the colon and the starts of the comma-separated fields.
// Depends on crp_pkg for phase encoding and the scanner info struct.
module crp_scanner (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic                       i_clear,
    input  logic [crp_pkg::BYTE_W-1:0] i_byte,
    output crp_pkg::t_scan_info        o_info
);
    import crp_pkg::*;

    t_scan_phase       r_phase, n_phase;
    logic [OFF_W-1:0]  r_offset, n_offset;
    logic [2:0]        r_seen, n_seen;
    logic [POS_W-1:0]  r_start_f2, n_start_f2;
    logic [POS_W-1:0]  r_start_f3, n_start_f3;
    logic [POS_W-1:0]  r_start_f4, n_start_f4;

    logic              in_range;
    logic              update;
    logic [POS_W-1:0]  pos;
    logic              is_comma;
    logic              is_space;

    // Bytes past the line limit do not touch the scan state.
    always_comb begin
        in_range = (r_offset < OFF_W'(MAX_LINE));
        update   = i_accept && in_range;
        pos      = POS_W'(r_offset);
        is_comma = (i_byte == CH_COMMA);
        is_space = (i_byte == CH_SPACE);
        n_offset = update ? (r_offset + OFF_W'(1)) : r_offset;
    end

    // Phase transitions and field start capture.
    always_comb begin
        n_phase    = r_phase;
        n_seen     = r_seen;
        n_start_f2 = r_start_f2;
        n_start_f3 = r_start_f3;
        n_start_f4 = r_start_f4;
        if (update) begin
            unique case (r_phase)
                PH_SEEK_COLON: begin
                    if (i_byte == CH_COLON) begin
                        n_phase = PH_SKIP_F1;
                    end
                end
                PH_SKIP_F1: begin
                    if (!is_space) begin
                        n_phase = is_comma ? PH_START_F2 : PH_IN_F1;
                    end
                end
                PH_IN_F1: begin
                    if (is_comma) begin
                        n_phase = PH_START_F2;
                    end
                end
                PH_START_F2: begin
                    // The second field starts right after its comma, spaces included.
                    n_seen[0]  = 1'b1;
                    n_start_f2 = pos;
                    n_phase    = is_comma ? PH_SKIP_F3 : PH_IN_F2;
                end
                PH_IN_F2: begin
                    if (is_comma) begin
                        n_phase = PH_SKIP_F3;
                    end
                end
                PH_SKIP_F3: begin
                    if (!is_space) begin
                        n_seen[1]  = 1'b1;
                        n_start_f3 = pos;
                        n_phase    = is_comma ? PH_SKIP_F4 : PH_IN_F3;
                    end
                end
                PH_IN_F3: begin
                    if (is_comma) begin
                        n_phase = PH_SKIP_F4;
                    end
                end
                PH_SKIP_F4: begin
                    if (!is_space) begin
                        n_seen[2]  = 1'b1;
                        n_start_f4 = pos;
                        n_phase    = PH_DONE;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_SEEK_COLON;
                end
            endcase
        end
    end

    // Report the state after this byte; the number parsers feed from it.
    always_comb begin
        o_info.in_range = in_range;
        o_info.active   = (n_phase != PH_SEEK_COLON) && (n_phase != PH_SKIP_F1);
        o_info.feed_f1  = update && o_info.active;
        o_info.feed_f2  = update && n_seen[0];
        o_info.seen     = n_seen;
        o_info.start_f2 = n_start_f2;
        o_info.start_f3 = n_start_f3;
        o_info.start_f4 = n_start_f4;
    end

    // State registers, cleared at the end of each line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_phase    <= PH_SEEK_COLON;
            r_offset   <= '0;
            r_seen     <= '0;
            r_start_f2 <= '0;
            r_start_f3 <= '0;
            r_start_f4 <= '0;
        end else begin
            r_phase    <= n_phase;
            r_offset   <= n_offset;
            r_seen     <= n_seen;
            r_start_f2 <= n_start_f2;
            r_start_f3 <= n_start_f3;
            r_start_f4 <= n_start_f4;
        end
    end

endmodule

FILE: sv/creg_response_field_parser_top.sv
// Top level of the registration reply field parser: scanner, two number parsers
// and the result register. Depends on crp_pkg, crp_if.sv, crp_scanner, crp_number.
//
//  Channel    Direction  Transfer carries
//  i_byte     in         line_byte, end_of_line
//  o_result   out        parse_ok, registered, reg_status, area/cell valid and position
//
// One byte is taken per cycle unless a finished result waits unread; the byte flagged
// end_of_line yields its result in the cycle after its transfer, from the output register.
// The scan and number state updates in the same cycle the byte is taken.
// i_byte.ready drops only while a finished result waits and o_result.ready is low.
// i_rst_n is synchronous and clears the scan state and the output valid.
`include "assert_macros.svh"

module creg_response_field_parser_top (
    input  logic   i_clk,
    input  logic   i_rst_n,
    crp_byte_if.sink     i_byte,
    crp_result_if.source o_result
);
    import crp_pkg::*;

    t_scan_info               scan;
    t_num_info                num_f1;
    t_num_info                num_f2;
    t_num_info                num_sel;

    logic                     accept;
    logic                     line_end;
    logic                     load;
    logic                     use_f2;
    logic                     good;

    logic                     r_out_valid;
    logic                     r_parse_ok, n_parse_ok;
    logic                     r_registered, n_registered;
    logic [STATUS_W-1:0]      r_reg_status, n_reg_status;
    logic                     r_area_valid, n_area_valid;
    logic [POS_W-1:0]         r_area_pos, n_area_pos;
    logic                     r_cell_valid, n_cell_valid;
    logic [POS_W-1:0]         r_cell_pos, n_cell_pos;

    // Handshake: the output register frees up as its result is taken.
    assign load         = !r_out_valid || o_result.ready;
    assign i_byte.ready = load;
    assign accept       = i_byte.valid && load;
    assign line_end     = accept && i_byte.end_of_line;

    crp_scanner u_scanner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_clear  (line_end),
        .i_byte   (i_byte.line_byte),
        .o_info   (scan)
    );

    crp_number u_num_f1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_feed  (scan.feed_f1),
        .i_clear (line_end),
        .i_byte  (i_byte.line_byte),
        .o_info  (num_f1)
    );

    crp_number u_num_f2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_feed  (scan.feed_f2),
        .i_clear (line_end),
        .i_byte  (i_byte.line_byte),
        .o_info  (num_f2)
    );

    // Pick the status field by the field pattern and format the result.
    always_comb begin
        use_f2  = (scan.seen == 3'b001) || (scan.seen == 3'b111);
        num_sel = use_f2 ? num_f2 : num_f1;
        good    = scan.active && num_sel.has_digits;

        n_parse_ok   = 1'b0;
        n_registered = 1'b0;
        n_reg_status = STATUS_ERR;
        n_area_valid = 1'b0;
        n_area_pos   = '0;
        n_cell_valid = 1'b0;
        n_cell_pos   = '0;
        if (good) begin
            n_parse_ok   = 1'b1;
            n_reg_status = num_sel.negative ? (STATUS_W'(0) - STATUS_W'(num_sel.value))
                                            : STATUS_W'(num_sel.value);
            n_registered = !num_sel.negative
                        && ((num_sel.value == NUM_W'(1)) || (num_sel.value == NUM_W'(5)));
            if (scan.seen == 3'b011) begin
                n_area_valid = 1'b1;
                n_area_pos   = scan.start_f2;
                n_cell_valid = 1'b1;
                n_cell_pos   = scan.start_f3;
            end else if (scan.seen[1] && scan.seen[2]) begin
                n_area_valid = 1'b1;
                n_area_pos   = scan.start_f3;
                n_cell_valid = 1'b1;
                n_cell_pos   = scan.start_f4;
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= line_end;
        end
    end

    // Output payload, loaded with each final byte of a line.
    always_ff @(posedge i_clk) begin
        if (line_end) begin
            r_parse_ok   <= n_parse_ok;
            r_registered <= n_registered;
            r_reg_status <= n_reg_status;
            r_area_valid <= n_area_valid;
            r_area_pos   <= n_area_pos;
            r_cell_valid <= n_cell_valid;
            r_cell_pos   <= n_cell_pos;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.parse_ok   = r_parse_ok;
    assign o_result.registered = r_registered;
    assign o_result.reg_status = $signed(r_reg_status);
    assign o_result.area_valid = r_area_valid;
    assign o_result.area_pos   = r_area_pos;
    assign o_result.cell_valid = r_cell_valid;
    assign o_result.cell_pos   = r_cell_pos;

    // A line end always leaves a result waiting in the next cycle.
    `CRP_ASSERT_NEXT(a_line_end_result, i_clk, i_rst_n, line_end, r_out_valid)
    // A failed parse carries the fixed error form.
    `CRP_ASSERT_IMPL(a_error_form, i_clk, i_rst_n, r_out_valid && !r_parse_ok, (r_reg_status == STATUS_ERR) && !r_registered && !r_area_valid && !r_cell_valid)
    // Area and cell positions are always found as a pair.
    `CRP_ASSERT_IMPL(a_area_cell_pair, i_clk, i_rst_n, r_out_valid, r_area_valid == r_cell_valid)
    // Registration implies status one or five.
    `CRP_ASSERT_IMPL(a_registered_status, i_clk, i_rst_n, r_out_valid && r_registered, r_parse_ok && ((r_reg_status == STATUS_W'(1)) || (r_reg_status == STATUS_W'(5))))

endmodule

FILE: tb/tb.sv
// Testbench for the registration reply field parser: drives reply lines byte by byte
// and checks every parse result against the directed table or a local line parser.
// Depends on crp_pkg, crp_if.sv and creg_response_field_parser_top.
`timescale 1ns / 1ps

module tb;
    import crp_pkg::*;

    // One parse result, in the order of the result channel fields.
    typedef struct packed {
        logic                ok;
        logic                registered;
        logic [STATUS_W-1:0] status;
        logic                area_valid;
        logic [POS_W-1:0]    area_pos;
        logic                cell_valid;
        logic [POS_W-1:0]    cell_pos;
    } t_reply;

    // One row of the directed table; the typed reply is used only when typed is set.
    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic              last;
        logic              typed;
        t_reply            want;
    } t_row;

    localparam t_reply REPLY_NONE = '0;
    localparam t_reply REPLY_ERR  = {1'b0, 1'b0, STATUS_ERR, 1'b0, 8'd0, 1'b0, 8'd0};
    localparam int     RANDOM_BYTES   = 1350;
    localparam int     MAX_REPORTED   = 10;
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    crp_byte_if   byte_if ();
    crp_result_if result_if ();

    creg_response_field_parser_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_if),
        .o_result (result_if)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Line parser state, mirrored from the block's behavior.
    t_scan_phase       scan_phase;
    int                scan_offset;
    logic [POS_W-1:0]  field_pos [3];
    logic              field_found [3];
    logic [NUM_W-1:0]  num_value [2];
    logic              num_negative [2];
    t_num_stage        num_stage [2];

    t_reply            expected_replies [$];
    logic [BYTE_W-1:0] line_q [$];
    t_row              directed_rows [$];
    int                error_count = 0;
    int                burst_left;
    int                bytes_sent;
    int                rx_stall_left;
    int                rx_cycle;
    t_reply            got_reply;
    t_reply            want_reply;
    string             reply_tag = "+CREG";

    function automatic void clear_line_state();
        scan_phase  = PH_SEEK_COLON;
        scan_offset = 0;
        for (int i = 0; i < 3; i++) begin
            field_pos[i]   = '0;
            field_found[i] = 1'b0;
        end
        for (int i = 0; i < 2; i++) begin
            num_value[i]    = '0;
            num_negative[i] = 1'b0;
            num_stage[i]    = NUM_SKIP;
        end
    endfunction

    // Field scanner: colon, then up to four comma-separated fields.
    function automatic void scan_field_byte(input logic [BYTE_W-1:0] c,
                                            input logic [POS_W-1:0] pos);
        case (scan_phase)
            PH_SEEK_COLON: begin
                if (c == CH_COLON) scan_phase = PH_SKIP_F1;
            end
            PH_SKIP_F1, PH_IN_F1: begin
                if (scan_phase == PH_SKIP_F1 && c != CH_SPACE) scan_phase = PH_IN_F1;
                if (scan_phase == PH_IN_F1 && c == CH_COMMA) scan_phase = PH_START_F2;
            end
            PH_START_F2, PH_IN_F2: begin
                // The second field starts right after its comma, spaces included.
                if (scan_phase == PH_START_F2) begin
                    field_pos[0]   = pos;
                    field_found[0] = 1'b1;
                    scan_phase     = PH_IN_F2;
                end
                if (c == CH_COMMA) scan_phase = PH_SKIP_F3;
            end
            PH_SKIP_F3, PH_IN_F3: begin
                if (scan_phase == PH_SKIP_F3 && c != CH_SPACE) begin
                    field_pos[1]   = pos;
                    field_found[1] = 1'b1;
                    scan_phase     = PH_IN_F3;
                end
                if (scan_phase == PH_IN_F3 && c == CH_COMMA) scan_phase = PH_SKIP_F4;
            end
            PH_SKIP_F4: begin
                if (c != CH_SPACE) begin
                    field_pos[2]   = pos;
                    field_found[2] = 1'b1;
                    scan_phase     = PH_DONE;
                end
            end
            default: ;
        endcase
    endfunction

    // Decimal number: white space, optional sign, digits saturating at 255.
    function automatic void accumulate_number(input int k, input logic [BYTE_W-1:0] c);
        logic is_digit;
        logic is_blank;
        int   v;
        is_digit = (c >= CH_ZERO && c <= CH_NINE);
        is_blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        case (num_stage[k])
            NUM_SKIP: begin
                if (is_blank) begin
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    num_negative[k] = (c == CH_MINUS);
                    num_stage[k]    = NUM_SIGN;
                end else if (is_digit) begin
                    num_value[k] = c - CH_ZERO;
                    num_stage[k] = NUM_DIGITS;
                end else begin
                    num_stage[k] = NUM_END_BAD;
                end
            end
            NUM_SIGN: begin
                if (is_digit) begin
                    num_value[k] = c - CH_ZERO;
                    num_stage[k] = NUM_DIGITS;
                end else begin
                    num_stage[k] = NUM_END_BAD;
                end
            end
            NUM_DIGITS: begin
                if (is_digit) begin
                    v = int'(num_value[k]) * RADIX + int'(c - CH_ZERO);
                    num_value[k] = (v > 255) ? NUM_SAT : v[NUM_W-1:0];
                end else begin
                    num_stage[k] = NUM_END_OK;
                end
            end
            default: ;
        endcase
    endfunction

    // Advances the line parser by one byte; returns 1 with the reply on the last byte.
    function automatic logic parse_reply_byte(input logic [BYTE_W-1:0] c, input logic last,
                                              output t_reply r);
        logic             f2, f3, f4;
        int               k;
        logic [NUM_W-1:0] mag;
        r = REPLY_ERR;
        // Bytes past the line limit are dropped, but the last one still ends the line.
        if (scan_offset < MAX_LINE) begin
            scan_field_byte(c, scan_offset[POS_W-1:0]);
            if (scan_phase >= PH_IN_F1) accumulate_number(0, c);
            if (field_found[0]) accumulate_number(1, c);
            scan_offset++;
        end
        if (!last) return 1'b0;

        if (scan_phase >= PH_IN_F1) begin
            f2 = field_found[0];
            f3 = field_found[1];
            f4 = field_found[2];
            // Status comes from the second field when it stands alone or with both others.
            k = ((f2 && !f3 && !f4) || (f2 && f3 && f4)) ? 1 : 0;
            if (num_stage[k] == NUM_DIGITS || num_stage[k] == NUM_END_OK) begin
                mag          = num_value[k];
                r.ok         = 1'b1;
                r.status     = num_negative[k] ? (~{1'b0, mag} + 9'd1) : {1'b0, mag};
                r.registered = !num_negative[k] && (mag == 8'd1 || mag == 8'd5);
                if (f2 && f3 && !f4) begin
                    r.area_valid = 1'b1;
                    r.area_pos   = field_pos[0];
                    r.cell_valid = 1'b1;
                    r.cell_pos   = field_pos[1];
                end else if (f3 && f4) begin
                    r.area_valid = 1'b1;
                    r.area_pos   = field_pos[1];
                    r.cell_valid = 1'b1;
                    r.cell_pos   = field_pos[2];
                end
            end
        end
        clear_line_state();
        return 1'b1;
    endfunction

    function automatic string reply_text(input t_reply r);
        return $sformatf("ok=%0b reg=%0b status=%0d area=%0b/%0d cell=%0b/%0d",
                         r.ok, r.registered, $signed(r.status), r.area_valid, r.area_pos,
                         r.cell_valid, r.cell_pos);
    endfunction

    // Sends one byte in bursts with idle gaps, then records the reply it completes.
    task automatic send_line_byte(input logic [BYTE_W-1:0] c, input logic last,
                                  input logic typed, input t_reply want);
        t_reply predicted;
        if (burst_left == 0) begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 12);
        end
        byte_if.valid       <= 1'b1;
        byte_if.line_byte   <= c;
        byte_if.end_of_line <= last;
        do @(posedge i_clk); while (!byte_if.ready);
        burst_left--;
        bytes_sent++;
        if (parse_reply_byte(c, last, predicted))
            expected_replies.push_back(typed ? want : predicted);
    endtask

    // Holds the byte channel idle until every pending reply has arrived.
    task automatic wait_for_replies();
        byte_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_replies.size() != 0);
    endtask

    task automatic add_blanks(input int max_n);
        int sel;
        repeat ($urandom_range(0, max_n)) begin
            sel = $urandom_range(0, 7);
            line_q.push_back(sel == 0 ? CH_TAB : sel == 1 ? CH_CR : sel == 2 ? CH_LF : CH_SPACE);
        end
    endtask

    // Decimal field, mostly short with the registered codes favored.
    task automatic add_number();
        int sel;
        int n;
        sel = $urandom_range(0, 9);
        if (sel == 0) line_q.push_back(CH_PLUS);
        if (sel == 1) line_q.push_back(CH_MINUS);
        sel = $urandom_range(0, 9);
        n = (sel < 6) ? 1 : (sel < 9) ? $urandom_range(2, 3) : $urandom_range(4, 6);
        if ($urandom_range(0, 2) == 0)
            line_q.push_back(CH_ZERO + ($urandom_range(0, 1) ? 8'd1 : 8'd5));
        else
            line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        repeat (n - 1) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Up to four fields: numbers first, quoted hex codes later, some empty or bad.
    task automatic add_fields();
        int nf;
        int sel;
        int h;
        nf = $urandom_range(1, 4);
        for (int i = 0; i < nf; i++) begin
            if (i > 0) line_q.push_back(CH_COMMA);
            if ($urandom_range(0, 3) == 0) add_blanks(2);
            sel = $urandom_range(0, 9);
            if (i < 2 || sel < 3) begin
                if (sel == 8) line_q.push_back("x");
                else if (sel != 9) add_number();
            end else begin
                line_q.push_back(CH_QUOTE);
                repeat (4) begin
                    h = $urandom_range(0, 15);
                    line_q.push_back(h < 10 ? CH_ZERO + 8'(h) : "A" + 8'(h - 10));
                end
                line_q.push_back(CH_QUOTE);
            end
        end
    endtask

    // Builds one line: mostly well formed, some broken, some noise, a few overlong.
    task automatic build_line();
        int kind;
        int pos;
        line_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 2) begin
            if ($urandom_range(0, 1)) begin
                repeat ($urandom_range(240, 270)) line_q.push_back("A" + 8'($urandom_range(0, 25)));
                line_q.push_back(CH_COLON);
            end else begin
                // Long run of spaces pushes the fields up against the line limit.
                line_q.push_back(CH_COLON);
                repeat ($urandom_range(230, 252)) line_q.push_back(CH_SPACE);
            end
            add_fields();
        end else if (kind < 12) begin
            if ($urandom_range(0, 2) == 0) line_q.push_back(CH_COLON);
            repeat ($urandom_range(1, 10)) line_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 4) != 0)
                for (int i = 0; i < reply_tag.len(); i++) line_q.push_back(reply_tag[i]);
            line_q.push_back(CH_COLON);
            if ($urandom_range(0, 2) == 0) add_blanks(2);
            add_fields();
            if ($urandom_range(0, 2) == 0) line_q.push_back(CH_CR);
            if (kind >= 80) begin
                pos = $urandom_range(0, line_q.size() - 1);
                case ($urandom_range(0, 2))
                    0: while (line_q.size() > pos + 1) line_q.delete(line_q.size() - 1);
                    1: line_q[pos] = 8'($urandom_range(0, 255));
                    default: line_q[pos] = $urandom_range(0, 1) ? CH_COMMA : CH_SPACE;
                endcase
            end
        end
    endtask

    // Result side ready: random stalls, with periodic stretches of none.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
            rx_stall_left   <= 0;
            rx_cycle        <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if ((rx_cycle / 400) % 4 == 3) begin
                result_if.ready <= 1'b1;
            end else if (rx_stall_left != 0) begin
                result_if.ready <= 1'b0;
                rx_stall_left   <= rx_stall_left - 1;
            end else if ($urandom_range(0, 3) == 0) begin
                result_if.ready <= 1'b0;
                rx_stall_left   <= $urandom_range(0, 7);
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // Compares each result transfer with the oldest pending reply.
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            got_reply = {result_if.parse_ok, result_if.registered, result_if.reg_status,
                         result_if.area_valid, result_if.area_pos,
                         result_if.cell_valid, result_if.cell_pos};
            if (expected_replies.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTED)
                    $display("unexpected result: %s", reply_text(got_reply));
            end else begin
                want_reply = expected_replies.pop_front();
                if (got_reply !== want_reply) begin
                    error_count++;
                    if (error_count <= MAX_REPORTED)
                        $display("mismatch: expected %s, got %s",
                                 reply_text(want_reply), reply_text(got_reply));
                end
            end
        end
    end

    // Stimulus: reset, directed table, random lines, then drain.
    initial begin
        int random_target;
        byte_if.valid       <= 1'b0;
        byte_if.line_byte   <= '0;
        byte_if.end_of_line <= 1'b0;
        burst_left  = 0;
        bytes_sent  = 0;
        clear_line_state();

        // Directed lines: registered, no colon, negative, empty field, bad status,
        // saturation, then the three and four field patterns.
        directed_rows = '{
            {CH_COLON, 1'b0, 1'b0, REPLY_NONE},
            {8'h31,    1'b1, 1'b1, {1'b1, 1'b1, 9'd1, 1'b0, 8'd0, 1'b0, 8'd0}},
            {8'hFF,    1'b1, 1'b1, REPLY_ERR},
            {CH_COLON, 1'b0, 1'b0, REPLY_NONE},
            {CH_MINUS, 1'b0, 1'b0, REPLY_NONE},
            {8'h39,    1'b1, 1'b1, {1'b1, 1'b0, 9'h1F7, 1'b0, 8'd0, 1'b0, 8'd0}},
            {CH_COLON, 1'b1, 1'b1, REPLY_ERR},
            {CH_COLON, 1'b0, 1'b0, REPLY_NONE},
            {8'h00,    1'b1, 1'b1, REPLY_ERR},
            {CH_COLON, 1'b0, 1'b0, REPLY_NONE},
            {8'h39,    1'b0, 1'b0, REPLY_NONE},
            {8'h39,    1'b0, 1'b0, REPLY_NONE},
            {8'h39,    1'b1, 1'b1, {1'b1, 1'b0, 9'd255, 1'b0, 8'd0, 1'b0, 8'd0}},
            {CH_COLON, 1'b0, 1'b0, REPLY_NONE},
            {8'h32,    1'b0, 1'b0, REPLY_NONE},
            {CH_COMMA, 1'b0, 1'b0, REPLY_NONE},
            {8'h31,    1'b0, 1'b0, REPLY_NONE},
            {CH_COMMA, 1'b0, 1'b0, REPLY_NONE},
            {8'h43,    1'b1, 1'b0, REPLY_NONE},
            {CH_COLON, 1'b0, 1'b0, REPLY_NONE},
            {8'h32,    1'b0, 1'b0, REPLY_NONE},
            {CH_COMMA, 1'b0, 1'b0, REPLY_NONE},
            {8'h35,    1'b0, 1'b0, REPLY_NONE},
            {CH_COMMA, 1'b0, 1'b0, REPLY_NONE},
            {8'h61,    1'b0, 1'b0, REPLY_NONE},
            {CH_COMMA, 1'b0, 1'b0, REPLY_NONE},
            {8'h62,    1'b1, 1'b0, REPLY_NONE}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_line_byte(directed_rows[i].line_byte, directed_rows[i].last,
                           directed_rows[i].typed, directed_rows[i].want);

        random_target = bytes_sent + RANDOM_BYTES;
        for (int line_no = 0; bytes_sent < random_target; line_no++) begin
            // Now and then let every pending result drain before the next line.
            if (line_no % 25 == 10) wait_for_replies();
            build_line();
            foreach (line_q[i])
                send_line_byte(line_q[i], i == line_q.size() - 1, 1'b0, REPLY_NONE);
        end

        wait_for_replies();
        repeat (4) @(posedge i_clk);
        if (error_count == 0 && expected_replies.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
